FILE: rtl/core/scfp_pkg.sv
// Shared types, constants and helpers for the serial command frame parser.
`default_nettype none

package scfp_pkg;

	// Largest payload a frame may carry, and the index width that covers it.
	localparam int MAX_PAYLOAD = 9;
	localparam int IDX_W       = $clog2(MAX_PAYLOAD + 1);

	// Frame delimiters.
	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] END_BYTE   = 8'hFE;

	// Accepted command IDs.
	localparam int NUM_IDS = 9;
	localparam logic [7:0] ID_LIST [NUM_IDS] = '{
		8'hFF, 8'hFB, 8'h25, 8'h37, 8'h01, 8'h13, 8'hFA, 8'hFC, 8'hF0
	};

	// Result kinds.
	typedef enum logic [1:0] {
		ST_PAYLOAD    = 2'd0,
		ST_ERROR      = 2'd1,
		ST_INCOMPLETE = 2'd2
	} status_t;

	// Parser phases, one-hot.
	typedef enum logic [5:0] {
		PH_START = 6'b000001,
		PH_ID    = 6'b000010,
		PH_LEN   = 6'b000100,
		PH_DATA  = 6'b001000,
		PH_END   = 6'b010000,
		PH_SKIP  = 6'b100000
	} phase_t;

	// Write request into the payload memory.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} wr_req_t;

	// One payload beat read back from the payload memory.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic [7:0]       data;
		logic             last;
	} beat_t;

	// True when the byte is one of the accepted command IDs.
	function automatic logic id_ok(input logic [7:0] b);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_IDS; k++) begin
			if (ID_LIST[k] == b) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scfp_emit.sv
// Payload memory and the read sequencer that plays a finished frame back.
`default_nettype none

module scfp_emit (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire scfp_pkg::wr_req_t        wr,
	input  wire logic                     start,
	input  wire logic [scfp_pkg::IDX_W-1:0] frame_len,
	input  wire logic                     take,
	output scfp_pkg::beat_t               beat,
	output logic                          busy
);
	import scfp_pkg::*;

	logic [7:0]       mem [MAX_PAYLOAD];
	logic             run_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             pend_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             last_s1;
	logic [7:0]       rd_data_s1;
	logic             issue;
	logic [IDX_W-1:0] rd_next;

	// A read goes out when the stage behind it is empty or drains this cycle.
	assign issue   = run_q && (!pend_s1 || take);
	assign rd_next = rd_idx_q + IDX_W'(1);

	// Payload memory: written during intake, read during playback.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

	// Read sequencer and the beat stage after the memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
			idx_s1   <= '0;
			last_s1  <= 1'b0;
		end else begin
			if (start) begin
				run_q    <= 1'b1;
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_next;
				if (rd_next == frame_len) begin
					run_q <= 1'b0;
				end
			end
			if (issue) begin
				pend_s1 <= 1'b1;
				idx_s1  <= rd_idx_q;
				last_s1 <= (rd_next == frame_len);
			end else if (take) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	assign beat.valid = pend_s1;
	assign beat.idx   = idx_s1;
	assign beat.data  = rd_data_s1;
	assign beat.last  = last_s1;
	assign busy       = run_q || pend_s1;

endmodule

`default_nettype wire

FILE: rtl/core/serial_command_frame_parser_unit.sv
// Top level of the serial command frame parser: byte intake, phase control and result register.
// An error or incomplete result appears in the cycle after its byte is accepted; the first payload
// result of a good frame goes through the playback start, the memory read stage and the result register.
// Throughput: one byte per cycle while the result register can take a result; after a good frame intake
// pauses while the payload memory is read back, one entry per cycle when the output does not stall.
// Reset: arst_n clears the phase to waiting for a start byte and empties the result register.
`default_nettype none

module serial_command_frame_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire logic        s_axis_tlast,   // buffer_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [7:0] frame_id, [11:8] frame_length,
	                                         // [15:12] byte_index, [23:16] payload_byte,
	                                         // [24] stop_motors, [31:25] zero
	output logic [1:0]       m_axis_tuser,   // [1:0] status
	output logic             m_axis_tlast    // last
);
	import scfp_pkg::*;

	phase_t           phase_q;
	phase_t           phase_nxt;
	logic [7:0]       held_id_q;
	logic [IDX_W-1:0] held_len_q;
	logic [IDX_W-1:0] count_q;

	// Result register.
	logic             out_valid_q;
	status_t          out_status_q;
	logic [7:0]       out_id_q;
	logic [IDX_W-1:0] out_len_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [7:0]       out_pay_q;
	logic             out_stop_q;
	logic             out_last_q;

	logic             take;
	logic             accept;
	logic             err;
	logic             frame_done;
	logic             incomplete;
	logic             len_ok;
	logic             pay_ok;
	logic             emit_busy;
	logic [7:0]       b;
	wr_req_t          wr;
	beat_t            beat;

	assign b      = s_axis_tdata;
	assign take   = !out_valid_q || m_axis_tready;
	assign len_ok = (b >= 8'd1) && (b <= 8'(MAX_PAYLOAD));
	assign pay_ok = (b != 8'h00) && (b != 8'hFF) && (count_q < IDX_W'(MAX_PAYLOAD));

	// Intake waits while a frame plays back, which keeps memory reads and writes apart.
	assign s_axis_tready = !emit_busy && take;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Next phase and what the current byte produces.
	always_comb begin
		phase_nxt  = phase_q;
		err        = 1'b0;
		frame_done = 1'b0;
		unique case (phase_q)
			PH_START: begin
				if (b == START_BYTE) phase_nxt = PH_ID;
				else                 err = 1'b1;
			end
			PH_ID: begin
				if (id_ok(b)) phase_nxt = PH_LEN;
				else          err = 1'b1;
			end
			PH_LEN: begin
				if (len_ok) phase_nxt = PH_DATA;
				else        err = 1'b1;
			end
			PH_DATA: begin
				if (pay_ok) begin
					if ((count_q + IDX_W'(1)) >= held_len_q) phase_nxt = PH_END;
				end else begin
					err = 1'b1;
				end
			end
			PH_END: begin
				if (b == END_BYTE) begin
					frame_done = 1'b1;
					phase_nxt  = PH_SKIP;
				end else begin
					err = 1'b1;
				end
			end
			PH_SKIP: phase_nxt = PH_SKIP;
			default: phase_nxt = PH_SKIP;
		endcase
		if (err) begin
			phase_nxt = PH_SKIP;
		end
		incomplete = s_axis_tlast && !err && !frame_done &&
			((phase_nxt == PH_ID) || (phase_nxt == PH_LEN) ||
			 (phase_nxt == PH_DATA) || (phase_nxt == PH_END));
		if (s_axis_tlast) begin
			phase_nxt = PH_START;
		end
	end

	// Payload bytes go into the memory at the running count.
	assign wr.en   = accept && (phase_q == PH_DATA) && pay_ok;
	assign wr.addr = count_q;
	assign wr.data = b;

	// Phase and frame header registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			held_id_q  <= '0;
			held_len_q <= '0;
			count_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			if ((phase_q == PH_ID) && id_ok(b)) begin
				held_id_q <= b;
			end
			if ((phase_q == PH_LEN) && len_ok) begin
				held_len_q <= b[IDX_W-1:0];
				count_q    <= '0;
			end
			if (wr.en) begin
				count_q <= count_q + IDX_W'(1);
			end
		end
	end

	scfp_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.start     (accept && frame_done),
		.frame_len (held_len_q),
		.take      (take),
		.beat      (beat),
		.busy      (emit_busy)
	);

	// Result register: loaded with a single error or incomplete result, or a payload beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && (err || incomplete)) || (beat.valid && take)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (err || incomplete)) begin
			out_status_q <= err ? ST_ERROR : ST_INCOMPLETE;
			out_id_q     <= '0;
			out_len_q    <= '0;
			out_idx_q    <= '0;
			out_pay_q    <= '0;
			out_stop_q   <= err;
			out_last_q   <= 1'b1;
		end else if (beat.valid && take) begin
			out_status_q <= ST_PAYLOAD;
			out_id_q     <= held_id_q;
			out_len_q    <= held_len_q;
			out_idx_q    <= beat.idx;
			out_pay_q    <= beat.data;
			out_stop_q   <= 1'b0;
			out_last_q   <= beat.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_stop_q, out_pay_q, out_idx_q, out_len_q, out_id_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: dv/tb_serial_command_frame_parser_unit.sv
// Self-checking testbench for the serial command frame parser with a stream-side predictor.
`default_nettype none

module tb_serial_command_frame_parser_unit;
	import scfp_pkg::*;

	// One byte request waiting to be driven; hold makes the driver wait for all results first.
	typedef struct packed {
		logic [7:0] rx;
		logic       fin;
		logic       hold;
	} byte_req_t;

	// One result as the parser should report it.
	typedef struct {
		status_t    status;
		logic [7:0] id;
		logic [3:0] len;
		logic [3:0] idx;
		logic [7:0] pay;
		logic       stop;
		logic       fin;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire logic   s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	wire logic   m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire logic [31:0] m_axis_tdata;
	wire logic [1:0]  m_axis_tuser;
	wire logic   m_axis_tlast;

	serial_command_frame_parser_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	byte_req_t  pending[$];
	result_t    frame_results[$];
	int         errors = 0;
	bit         calm = 1'b0;
	logic       in_taken = 1'b0;
	int         src_gap = 0;
	int         sink_gap = 0;
	result_t    want;

	// Predictor state: parse phase, header fields and the payload bytes of the current frame.
	phase_t     ph = PH_START;
	logic [7:0] cur_id = 8'h00;
	logic [3:0] cur_len = 4'd0;
	logic [3:0] got = 4'd0;
	logic [7:0] payload_seen [MAX_PAYLOAD];

	logic [7:0] command_ids [9] = '{
		8'hFF, 8'hFB, 8'h25, 8'h37, 8'h01, 8'h13, 8'hFA, 8'hFC, 8'hF0
	};

	task automatic add_req(input logic [7:0] b, input logic fin, input logic hold);
		byte_req_t r;
		r.rx = b;
		r.fin = fin;
		r.hold = hold;
		pending.push_back(r);
	endtask

	task automatic note_result(input status_t st, input logic [7:0] id, input logic [3:0] len,
			input logic [3:0] idx, input logic [7:0] pay, input logic stop, input logic fin);
		result_t r;
		r.status = st;
		r.id = id;
		r.len = len;
		r.idx = idx;
		r.pay = pay;
		r.stop = stop;
		r.fin = fin;
		frame_results.push_back(r);
	endtask

	// Advance the parse state by one accepted byte and queue the results it causes.
	task automatic parse_byte(input logic [7:0] b, input logic fin);
		bit fault;
		bit known_id;
		int produced;
		fault = 1'b0;
		produced = 0;
		case (ph)
			PH_START: begin
				if (b == START_BYTE) ph = PH_ID;
				else fault = 1'b1;
			end
			PH_ID: begin
				case (b)
					8'hFF, 8'hFB, 8'h25, 8'h37, 8'h01, 8'h13, 8'hFA, 8'hFC, 8'hF0: known_id = 1'b1;
					default: known_id = 1'b0;
				endcase
				if (known_id) begin
					cur_id = b;
					ph = PH_LEN;
				end else begin
					fault = 1'b1;
				end
			end
			PH_LEN: begin
				if (b >= 8'd1 && b <= MAX_PAYLOAD) begin
					cur_len = b[3:0];
					got = 4'd0;
					ph = PH_DATA;
				end else begin
					fault = 1'b1;
				end
			end
			PH_DATA: begin
				if (b != 8'h00 && b != 8'hFF && got < MAX_PAYLOAD) begin
					payload_seen[got] = b;
					got = got + 4'd1;
					if (got >= cur_len) ph = PH_END;
				end else begin
					fault = 1'b1;
				end
			end
			PH_END: begin
				if (b == END_BYTE) begin
					for (int k = 0; k < cur_len; k++) begin
						note_result(ST_PAYLOAD, cur_id, cur_len, k[3:0], payload_seen[k], 1'b0,
							k + 1 == cur_len);
					end
					produced = int'(cur_len);
					ph = PH_SKIP;
				end else begin
					fault = 1'b1;
				end
			end
			default: ph = PH_SKIP;
		endcase

		// A format violation reports once and discards the rest of the buffer.
		if (fault) begin
			note_result(ST_ERROR, 8'h00, 4'd0, 4'd0, 8'h00, 1'b1, 1'b1);
			produced = 1;
			ph = PH_SKIP;
		end

		// The buffer end reports an unfinished frame only when this byte reported nothing.
		if (fin) begin
			if (produced == 0 && (ph == PH_ID || ph == PH_LEN || ph == PH_DATA || ph == PH_END)) begin
				note_result(ST_INCOMPLETE, 8'h00, 4'd0, 4'd0, 8'h00, 1'b0, 1'b1);
			end
			ph = PH_START;
		end
	endtask

	task automatic check_field(input string what, input int unsigned want_v, input int unsigned got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
			errors++;
		end
	endtask

	// Source side: present the next request, idle in random bursts, hold off where asked.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!(s_axis_tvalid && !in_taken)) begin
			calm = pending.size() < 40;
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending.size() == 0 || (pending[0].hold && frame_results.size() != 0)) begin
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				src_gap = $urandom_range(0, 9);
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending[0].rx;
				s_axis_tlast  <= pending[0].fin;
				void'(pending.pop_front());
			end
		end
	end

	// Sink side: stall in random bursts until the closing stretch.
	always @(negedge clk) begin
		if (sink_gap > 0) begin
			sink_gap--;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			sink_gap = $urandom_range(0, 9);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Request monitor: every accepted byte goes through the predictor.
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			parse_byte(s_axis_tdata, s_axis_tlast);
		end
	end

	// Result monitor: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (frame_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tuser %0h tdata %0h tlast %0b",
					$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = frame_results.pop_front();
				check_field("status", want.status, m_axis_tuser);
				check_field("frame_id", want.id, m_axis_tdata[7:0]);
				check_field("frame_length", want.len, m_axis_tdata[11:8]);
				check_field("byte_index", want.idx, m_axis_tdata[15:12]);
				check_field("payload_byte", want.pay, m_axis_tdata[23:16]);
				check_field("stop_motors", want.stop, m_axis_tdata[24]);
				check_field("tdata padding", 0, m_axis_tdata[31:25]);
				check_field("last", want.fin, m_axis_tlast);
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [7:0] fbytes [16];
		int kind;
		int flen;
		int n;
		int nbuf;
		int target;

		// Good one-byte frame whose end byte closes the buffer.
		add_req(8'hFF, 1'b0, 1'b0); add_req(8'hFF, 1'b0, 1'b0); add_req(8'h01, 1'b0, 1'b0);
		add_req(8'h01, 1'b0, 1'b0); add_req(8'hFE, 1'b1, 1'b0);
		// Good frame with the top payload value, then bytes discarded until the buffer ends.
		add_req(8'hFF, 1'b0, 1'b1); add_req(8'hF0, 1'b0, 1'b0); add_req(8'h02, 1'b0, 1'b0);
		add_req(8'hFE, 1'b0, 1'b0); add_req(8'h80, 1'b0, 1'b0); add_req(8'hFE, 1'b0, 1'b0);
		add_req(8'h55, 1'b0, 1'b0); add_req(8'hAA, 1'b1, 1'b0);
		// Buffer ends after the ID byte.
		add_req(8'hFF, 1'b0, 1'b0); add_req(8'h25, 1'b1, 1'b0);
		// Wrong first byte, alone in its buffer.
		add_req(8'h00, 1'b1, 1'b0);
		// Zero length, then discarded bytes.
		add_req(8'hFF, 1'b0, 1'b0); add_req(8'h37, 1'b0, 1'b0); add_req(8'h00, 1'b0, 1'b0);
		add_req(8'h12, 1'b1, 1'b0);
		// Length one above the maximum on the last byte.
		add_req(8'hFF, 1'b0, 1'b0); add_req(8'h13, 1'b0, 1'b0); add_req(8'h0A, 1'b1, 1'b0);
		// Zero payload byte on the last byte.
		add_req(8'hFF, 1'b0, 1'b0); add_req(8'hFB, 1'b0, 1'b0); add_req(8'h01, 1'b0, 1'b0);
		add_req(8'h00, 1'b1, 1'b0);

		// Random buffers: mostly good frames, some truncated, corrupted or pure noise.
		target = 230;
		nbuf = 0;
		while (pending.size() < target) begin
			kind = $urandom_range(0, 9);
			flen = $urandom_range(1, MAX_PAYLOAD);
			fbytes[0] = START_BYTE;
			fbytes[1] = command_ids[$urandom_range(0, 8)];
			fbytes[2] = 8'(flen);
			for (int k = 0; k < flen; k++) fbytes[3 + k] = 8'($urandom_range(1, 254));
			fbytes[3 + flen] = END_BYTE;
			n = flen + 4;
			if (kind == 6) begin
				n = $urandom_range(1, n - 1);
			end else if (kind == 9) begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++) fbytes[k] = 8'($urandom_range(0, 255));
			end else begin
				if (kind >= 7) fbytes[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
				for (int k = $urandom_range(0, 3); k > 0; k--) begin
					fbytes[n] = 8'($urandom_range(0, 255));
					n++;
				end
			end
			for (int k = 0; k < n; k++) begin
				add_req(fbytes[k], k == n - 1, k == 0 && nbuf % 25 == 0);
			end
			nbuf++;
		end

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || s_axis_tvalid || frame_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_serial_command_frame_parser_unit OK");
		end else begin
			$display("tb_serial_command_frame_parser_unit NOT OK");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5000000;
		$display("tb_serial_command_frame_parser_unit NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
